@@ src/pll_pkg.sv @@
package pll_pkg;

	localparam int CAPACITY_DEF = 256;

	localparam int MODE_W  = 2;
	localparam int POS_W   = 9;
	localparam int VAL_W   = 32;
	localparam int ST_W    = 2;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 48;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

endpackage

@@ src/positional_linked_list.sv @@
// Ordered list of up to CAPACITY signed 32-bit values kept in two slot memories
// (values and next links) with a free chain of released slots. Each transfer on
// s_axis inserts a value at a 1-based position, removes the element at a
// position, or reads it, and yields exactly one transfer on m_axis carrying a
// status, the element read or removed, the element count and an empty flag.
// One request is worked on at a time. A request reaches its position by
// following links through the link memory's single read port, one link per
// cycle. A finished result waits in the output register while the next
// request is taken in.
module positional_linked_list #(
	parameter int CAPACITY = pll_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [pll_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // position, value
	input  logic [pll_pkg::MODE_W-1:0]     s_axis_tuser,  // mode
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [pll_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // element, count, is_empty
	output logic [pll_pkg::ST_W-1:0]       m_axis_tuser   // status
);

	localparam int SW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int PW   = pll_pkg::POS_W;
	localparam int VW   = pll_pkg::VAL_W;
	localparam int MW   = pll_pkg::MODE_W;
	localparam int CMPW = ((CW > PW) ? CW : PW) + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ALLOC = 4'd1;
	localparam logic [3:0] S_WALK  = 4'd2;
	localparam logic [3:0] S_LREAD = 4'd3;
	localparam logic [3:0] S_LWAIT = 4'd4;
	localparam logic [3:0] S_INSW2 = 4'd5;
	localparam logic [3:0] S_INS1  = 4'd6;
	localparam logic [3:0] S_RM1   = 4'd7;
	localparam logic [3:0] S_RMV   = 4'd8;
	localparam logic [3:0] S_RMF   = 4'd9;
	localparam logic [3:0] S_VREAD = 4'd10;
	localparam logic [3:0] S_VWAIT = 4'd11;
	localparam logic [3:0] S_DONE  = 4'd12;

	logic [3:0]    state_q;
	logic [MW-1:0] mode_q;
	logic [PW-1:0] pos_q;
	logic [VW-1:0] val_q;
	logic [SW-1:0] first_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] unused_q;
	logic [SW-1:0] free_top_q;
	logic [SW-1:0] tgt_q;
	logic [SW-1:0] slot_q;
	logic [PW-1:0] rem_q;
	logic [pll_pkg::ST_W-1:0] status_q;
	logic [VW-1:0] elem_q;

	logic                     out_valid_q;
	logic [pll_pkg::ST_W-1:0] out_status_q;
	logic [VW-1:0]            out_elem_q;
	logic [PW-1:0]            out_count_q;
	logic                     out_empty_q;

	logic [MW-1:0]   in_mode;
	logic [PW-1:0]   in_pos;
	logic [VW-1:0]   in_val;
	logic [CMPW-1:0] pos_e;
	logic [CMPW-1:0] cnt_e;
	logic            ins_bad;
	logic            rr_bad;
	logic            is_full;
	logic            free_avail;
	logic [MW-1:0]   cur_mode;
	logic [PW-1:0]   wt;
	logic [3:0]      after_st;
	logic            accept;
	logic            out_load;

	logic          link_we;
	logic [SW-1:0] link_waddr;
	logic [SW-1:0] link_wdata;
	logic [SW-1:0] link_raddr;
	logic [SW-1:0] link_rdata;
	logic          val_we;
	logic [SW-1:0] val_raddr;
	logic [VW-1:0] val_rdata;

	assign in_mode = s_axis_tuser;
	assign in_pos  = s_axis_tdata[PW-1:0];
	assign in_val  = s_axis_tdata[PW+VW-1:PW];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	assign pos_e      = CMPW'(in_pos);
	assign cnt_e      = CMPW'(count_q);
	assign ins_bad    = (in_pos == '0) || (pos_e > cnt_e + CMPW'(1));
	assign rr_bad     = (in_pos == '0) || (pos_e > cnt_e);
	assign is_full    = (count_q == CW'(CAPACITY));
	assign free_avail = (unused_q != count_q);

	assign cur_mode = (state_q == S_IDLE) ? in_mode : mode_q;
	assign after_st = (cur_mode == pll_pkg::MODE_READ) ? S_VREAD : S_LREAD;

	always_comb begin
		if (state_q == S_IDLE) begin
			wt = (in_mode == pll_pkg::MODE_READ) ? in_pos : in_pos - PW'(1);
		end else begin
			wt = pos_q - PW'(1);
		end
	end

	always_comb begin
		unique case (state_q)
			S_IDLE:  link_raddr = (in_mode == pll_pkg::MODE_INSERT && free_avail) ?
			                      free_top_q : first_q;
			S_WALK:  link_raddr = link_rdata;
			S_LREAD: link_raddr = tgt_q;
			S_LWAIT: link_raddr = link_rdata;
			default: link_raddr = first_q;
		endcase
		unique case (state_q)
			S_VREAD: val_raddr = tgt_q;
			S_LWAIT: val_raddr = link_rdata;
			default: val_raddr = first_q;
		endcase
		link_we    = 1'b0;
		link_waddr = slot_q;
		link_wdata = first_q;
		val_we     = 1'b0;
		unique case (state_q)
			S_LWAIT: begin
				if (mode_q == pll_pkg::MODE_INSERT) begin
					link_we    = 1'b1;
					link_wdata = link_rdata;
					val_we     = 1'b1;
				end
			end
			S_INSW2: begin
				link_we    = 1'b1;
				link_waddr = tgt_q;
				link_wdata = slot_q;
			end
			S_INS1: begin
				link_we = 1'b1;
				val_we  = 1'b1;
			end
			S_RMV: begin
				link_we    = 1'b1;
				link_waddr = tgt_q;
				link_wdata = link_rdata;
			end
			S_RMF: begin
				link_we    = 1'b1;
				link_wdata = free_top_q;
			end
			default: begin
			end
		endcase
	end

	pll_ram #(
		.WIDTH (SW),
		.DEPTH (CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	pll_ram #(
		.WIDTH (VW),
		.DEPTH (CAPACITY)
	) u_value_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (slot_q),
		.wdata (val_q),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			first_q    <= '0;
			count_q    <= '0;
			unused_q   <= '0;
			free_top_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_mode == pll_pkg::MODE_INSERT) begin
							if (ins_bad || is_full) begin
								state_q <= S_DONE;
							end else if (free_avail) begin
								state_q <= S_ALLOC;
							end else begin
								unused_q <= unused_q + CW'(1);
								if (in_pos == PW'(1)) begin
									state_q <= S_INS1;
								end else if (wt == PW'(1)) begin
									state_q <= after_st;
								end else begin
									state_q <= S_WALK;
								end
							end
						end else if (in_mode == pll_pkg::MODE_REMOVE ||
						             in_mode == pll_pkg::MODE_READ) begin
							if (count_q == '0 || rr_bad) begin
								state_q <= S_DONE;
							end else if (in_mode == pll_pkg::MODE_REMOVE &&
							             in_pos == PW'(1)) begin
								state_q <= S_RM1;
							end else if (wt == PW'(1)) begin
								state_q <= after_st;
							end else begin
								state_q <= S_WALK;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_ALLOC: begin
					free_top_q <= link_rdata;
					if (pos_q == PW'(1)) begin
						state_q <= S_INS1;
					end else if (wt == PW'(1)) begin
						state_q <= after_st;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (rem_q == '0) begin
						state_q <= after_st;
					end
				end
				S_LREAD: state_q <= S_LWAIT;
				S_LWAIT: begin
					state_q <= (mode_q == pll_pkg::MODE_INSERT) ? S_INSW2 : S_RMV;
				end
				S_INSW2: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_INS1: begin
					first_q <= slot_q;
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_RM1: begin
					first_q <= link_rdata;
					state_q <= S_RMF;
				end
				S_RMV:   state_q <= S_RMF;
				S_RMF: begin
					free_top_q <= slot_q;
					count_q    <= count_q - CW'(1);
					state_q    <= S_DONE;
				end
				S_VREAD: state_q <= S_VWAIT;
				S_VWAIT: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				mode_q   <= in_mode;
				pos_q    <= in_pos;
				val_q    <= in_val;
				elem_q   <= '0;
				tgt_q    <= first_q;
				rem_q    <= wt - PW'(2);
				slot_q   <= unused_q[SW-1:0];
				status_q <= pll_pkg::ST_OK;
				if (in_mode == pll_pkg::MODE_INSERT) begin
					if (ins_bad) begin
						status_q <= pll_pkg::ST_BADPOS;
					end else if (is_full) begin
						status_q <= pll_pkg::ST_FULL;
					end
				end else if (in_mode == pll_pkg::MODE_REMOVE ||
				             in_mode == pll_pkg::MODE_READ) begin
					if (count_q == '0) begin
						status_q <= pll_pkg::ST_EMPTY;
					end else if (rr_bad) begin
						status_q <= pll_pkg::ST_BADPOS;
					end
				end else begin
					status_q <= pll_pkg::ST_BADPOS;
				end
			end
			S_ALLOC: begin
				slot_q <= free_top_q;
				tgt_q  <= first_q;
				rem_q  <= wt - PW'(2);
			end
			S_WALK: begin
				tgt_q <= link_rdata;
				rem_q <= rem_q - PW'(1);
			end
			S_LWAIT: begin
				if (mode_q != pll_pkg::MODE_INSERT) begin
					slot_q <= link_rdata;
				end
			end
			S_RM1: begin
				slot_q <= first_q;
				elem_q <= val_rdata;
			end
			S_RMV:   elem_q <= val_rdata;
			S_VWAIT: elem_q <= val_rdata;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_elem_q   <= elem_q;
			out_count_q  <= cnt_e[PW-1:0];
			out_empty_q  <= (count_q == '0);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {(pll_pkg::M_TDATA_W - VW - PW - 1)'(0), out_empty_q,
	                        out_count_q, out_elem_q};

endmodule

@@ src/pll_ram.sv @@
module pll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	typedef logic [pll_pkg::MODE_W-1:0] mode_t;
	typedef logic [pll_pkg::POS_W-1:0]  pos_t;
	typedef logic [pll_pkg::VAL_W-1:0]  val_t;

	localparam mode_t MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [pll_pkg::ST_W-1:0] status;
		val_t                     element;
		pos_t                     count;
		logic                     is_empty;
	} list_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_axis_tvalid = 1'b0;
	logic                          s_axis_tready;
	logic [pll_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	mode_t                         s_axis_tuser = '0;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready = 1'b0;
	logic [pll_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic [pll_pkg::ST_W-1:0]      m_axis_tuser;

	val_t             list_values[$];
	list_result_t     pending_results[$];
	int               error_count = 0;
	int               src_idle_pct = 0;
	int               sink_idle_pct = 0;

	positional_linked_list DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // position, value
		.s_axis_tuser  (s_axis_tuser),  // mode
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),  // element, count, is_empty
		.m_axis_tuser  (m_axis_tuser)   // status
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	function automatic list_result_t apply_request(mode_t mode, pos_t pos, val_t val);
		list_result_t r;
		int n;
		n = list_values.size();
		r.status = pll_pkg::ST_OK;
		r.element = '0;
		case (mode)
			pll_pkg::MODE_INSERT: begin
				if (pos < 1 || pos > n + 1)
					r.status = pll_pkg::ST_BADPOS;
				else if (n >= pll_pkg::CAPACITY_DEF)
					r.status = pll_pkg::ST_FULL;
				else
					list_values.insert(pos - 1, val);
			end
			pll_pkg::MODE_REMOVE, pll_pkg::MODE_READ: begin
				if (n == 0) begin
					r.status = pll_pkg::ST_EMPTY;
				end else if (pos < 1 || pos > n) begin
					r.status = pll_pkg::ST_BADPOS;
				end else begin
					r.element = list_values[pos - 1];
					if (mode == pll_pkg::MODE_REMOVE)
						list_values.delete(pos - 1);
				end
			end
			default: r.status = pll_pkg::ST_BADPOS;
		endcase
		r.count = pos_t'(list_values.size());
		r.is_empty = (list_values.size() == 0);
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge with tvalid still high
	task automatic send_request(mode_t mode, pos_t pos, val_t val);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(pll_pkg::S_TDATA_W - pll_pkg::POS_W - pll_pkg::VAL_W){1'b0}},
		                  val, pos};
		s_axis_tuser  <= mode;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(apply_request(mode, pos, val));
		@(negedge clk);
	endtask

	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	function automatic val_t pick_value();
		case ($urandom_range(0, 15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: tdata %h tuser %h",
				       m_axis_tdata, m_axis_tuser);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_axis_tuser !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, m_axis_tuser);
					error_count++;
				end
				if (m_axis_tdata[31:0] !== exp_r.element) begin
					$error("element: expected %h, actual %h", exp_r.element, m_axis_tdata[31:0]);
					error_count++;
				end
				if (m_axis_tdata[40:32] !== exp_r.count) begin
					$error("count: expected %0d, actual %0d", exp_r.count, m_axis_tdata[40:32]);
					error_count++;
				end
				if (m_axis_tdata[41] !== exp_r.is_empty) begin
					$error("is_empty: expected %0d, actual %0d", exp_r.is_empty, m_axis_tdata[41]);
					error_count++;
				end
			end
		end
	end

	task automatic test_edge_cases();
		send_request(pll_pkg::MODE_READ,   9'd1,   32'h1234_5678);
		send_request(pll_pkg::MODE_REMOVE, 9'd0,   32'h0);
		send_request(pll_pkg::MODE_REMOVE, 9'd511, 32'h0);
		send_request(pll_pkg::MODE_READ,   9'd0,   32'h0);
		send_request(pll_pkg::MODE_INSERT, 9'd0,   32'h5555_5555);
		send_request(pll_pkg::MODE_INSERT, 9'd2,   32'hAAAA_AAAA);
		send_request(pll_pkg::MODE_INSERT, 9'd511, 32'hFFFF_FFFF);
		send_request(MODE_UNUSED,          9'd1,   32'h1);
		send_request(pll_pkg::MODE_INSERT, 9'd1,   32'h8000_0000);
		send_request(pll_pkg::MODE_INSERT, 9'd2,   32'h7FFF_FFFF);
		send_request(pll_pkg::MODE_INSERT, 9'd1,   32'h0000_0000);
		send_request(pll_pkg::MODE_INSERT, 9'd4,   32'hFFFF_FFFF);
		send_request(pll_pkg::MODE_INSERT, 9'd6,   32'h1111_1111);
		for (int p = 1; p <= 5; p++)
			send_request(pll_pkg::MODE_READ, p[pll_pkg::POS_W-1:0], 32'hFFFF_FFFF);
		send_request(MODE_UNUSED,          9'd2,   32'h0);
		send_request(pll_pkg::MODE_REMOVE, 9'd4,   32'h0);
		send_request(pll_pkg::MODE_REMOVE, 9'd2,   32'h0);
		send_request(pll_pkg::MODE_REMOVE, 9'd1,   32'h0);
		send_request(pll_pkg::MODE_REMOVE, 9'd2,   32'h0);
		send_request(pll_pkg::MODE_REMOVE, 9'd1,   32'h0);
		send_request(pll_pkg::MODE_READ,   9'd1,   32'h0);
		wait_for_results();
	endtask

	task automatic test_full_list();
		int n;
		while (list_values.size() < pll_pkg::CAPACITY_DEF) begin
			n = list_values.size();
			send_request(pll_pkg::MODE_INSERT, pos_t'($urandom_range(1, n + 1)),
			             pick_value());
		end
		send_request(pll_pkg::MODE_INSERT, 9'd1, 32'h1);
		send_request(pll_pkg::MODE_INSERT, 9'd257, 32'h2);
		send_request(pll_pkg::MODE_INSERT, 9'd258, 32'h3);
		send_request(pll_pkg::MODE_INSERT, 9'd0, 32'h4);
		send_request(pll_pkg::MODE_READ, 9'd256, 32'h0);
		send_request(pll_pkg::MODE_READ, 9'd257, 32'h0);
		wait_for_results();
		while (list_values.size() > 0) begin
			n = list_values.size();
			if ($urandom_range(0, 3) == 0)
				send_request(pll_pkg::MODE_READ, pos_t'($urandom_range(1, n)), $urandom());
			send_request(pll_pkg::MODE_REMOVE, pos_t'($urandom_range(1, n)), $urandom());
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic(int items, int src_pct, int sink_pct);
		int target;
		int n;
		int limit;
		int pick;
		mode_t mode;
		pos_t pos;
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		target = 16;
		for (int i = 0; i < items; i++) begin
			if (i % 50 == 0)
				target = ($urandom_range(0, 7) == 0) ? $urandom_range(0, pll_pkg::CAPACITY_DEF)
				                                      : $urandom_range(0, 48);
			if ($urandom_range(0, 99) == 0)
				wait_for_results();
			n = list_values.size();
			pick = $urandom_range(0, 99);
			if (pick < 20)
				mode = pll_pkg::MODE_READ;
			else if (pick < 95)
				mode = ((pick < 60) == (n < target)) ? pll_pkg::MODE_INSERT : pll_pkg::MODE_REMOVE;
			else
				mode = mode_t'($urandom_range(0, 3));
			limit = (mode == pll_pkg::MODE_INSERT) ? n + 1 : n;
			if (pick >= 95 || limit == 0)
				pos = ($urandom_range(0, 1) == 0) ? 9'd0 : pos_t'($urandom_range(limit + 1, 511));
			else
				pos = pos_t'($urandom_range(1, limit));
			send_request(mode, pos, pick_value());
		end
		wait_for_results();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		src_idle_pct = 28;
		sink_idle_pct = 48;
		test_edge_cases();
		test_full_list();
		test_random_traffic(300, 28, 48);
		test_random_traffic(300, 48, 28);
		test_random_traffic(300, 0, 0);
		repeat (300) @(posedge clk);
		if (pending_results.size() != 0)
			$error("%0d results never arrived", pending_results.size());
		if (error_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#40ms;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ files.f @@
src/pll_pkg.sv
src/pll_ram.sv
src/positional_linked_list.sv
verif/tb_top.sv
